// ----- design/see_pkg.sv -----
package see_pkg;

   localparam int MAG_W          = 24;
   localparam int POINT_IDX_W    = 6;
   localparam int SMOOTH_W       = 8;
   localparam int TARGET_W       = 7;
   localparam int HALF_W         = 7;
   localparam int FRAC_W         = 16;
   localparam int SUM_W          = 32;
   localparam int DVS_W          = 8;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;
   localparam int MAX_BINS_DEF   = 1024;
   localparam int MAX_POINTS_DEF = 64;

   localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 8'd8;
   localparam logic [TARGET_W-1:0] TARGET_RESET = 7'd64;
   localparam logic [TARGET_W-1:0] TARGET_MIN   = 7'd2;

   localparam logic REG_SMOOTH = 1'b0;
   localparam logic REG_TARGET = 1'b1;

   localparam int RES_W = MAG_W + POINT_IDX_W + 2;

endpackage

// ----- design/spectral_envelope_extractor.sv -----
// bins load at one per cycle while req_full is low; the last bin of a frame closes it and the input then stalls
// smoothing rounds each bin's window mean on the bit-serial divider (DW = 33 by default)
// resampling finds each point's position on the same shared divider; if n <= target, bins are copied
// results are queued only after every bin of the frame is smoothed
// the next frame loads once the last result of the frame is queued
// synchronous active-high reset clears control state and sets the registers to their defaults
module spectral_envelope_extractor #(
   parameter int MAX_BINS   = see_pkg::MAX_BINS_DEF,
   parameter int MAX_POINTS = see_pkg::MAX_POINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [see_pkg::MAG_W-1:0]        req_magnitude,
   input  logic                             req_last_bin,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [see_pkg::MAG_W-1:0]        rsp_envelope_value,
   output logic [see_pkg::POINT_IDX_W-1:0]  rsp_point_index,
   output logic                             rsp_last_point,
   output logic                             rsp_truncated,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [see_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [see_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [see_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import see_pkg::*;

   localparam int AW = $clog2(MAX_BINS);
   localparam int CW = AW + 1;
   localparam int MW = $clog2(MAX_POINTS) + 1;
   localparam int JW = CW + MW + HALF_W + 1;

   logic [SMOOTH_W-1:0] smooth_ff;
   logic [TARGET_W-1:0] target_ff;
   logic                csr_wr;

   logic                job_push, job_pop, job_full, job_empty;
   logic [JW-1:0]       job_in, job_out;
   logic                frame_done;
   logic [AW-1:0]       bin_addr;
   logic [MAG_W-1:0]    bin_rdata;
   logic                res_push, res_full;
   logic [RES_W-1:0]    res_in, res_out;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_SMOOTH) ? CSR_DATA_W'(smooth_ff)
                                                    : CSR_DATA_W'(target_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= SMOOTH_RESET;
         target_ff <= TARGET_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_SMOOTH) begin
            smooth_ff <= csr_pwdata[SMOOTH_W-1:0];
         end else if (csr_paddr[2] == REG_TARGET) begin
            target_ff <= csr_pwdata[TARGET_W-1:0];
         end
      end
   end

   see_front #(.MAX_BINS(MAX_BINS), .MAX_POINTS(MAX_POINTS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (req_push),
      .magnitude       (req_magnitude),
      .last_bin        (req_last_bin),
      .full            (req_full),
      .smoothing_width (smooth_ff),
      .target_points   (target_ff),
      .job_push        (job_push),
      .job_data        (job_in),
      .job_full        (job_full),
      .frame_done      (frame_done),
      .bin_addr        (bin_addr),
      .bin_rdata       (bin_rdata)
   );

   see_fifo #(.WIDTH(JW), .DEPTH(2)) u_jobq (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty)
   );

   see_back #(.MAX_BINS(MAX_BINS), .MAX_POINTS(MAX_POINTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_empty  (job_empty),
      .job_data   (job_out),
      .job_pop    (job_pop),
      .bin_addr   (bin_addr),
      .bin_rdata  (bin_rdata),
      .res_push   (res_push),
      .res_data   (res_in),
      .res_full   (res_full),
      .frame_done (frame_done)
   );

   see_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_resq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out),
      .empty     (rsp_empty)
   );

   assign {rsp_envelope_value, rsp_point_index, rsp_last_point, rsp_truncated} = res_out;

   a_res_no_overrun: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result queue overrun");

   a_job_no_overrun: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("job queue overrun");

   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_last_bin) |=> req_full)
      else $error("input not stalled after frame end");

endmodule

// ----- design/see_fifo.sv -----
module see_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem[rp_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == PTR_W'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_pop) begin
         rp_in = (rp_ff == PTR_W'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wp_ff] <= push_data;
      end
   end

endmodule

// ----- design/see_div.sv -----
module see_div #(
   parameter int DW = 33
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DW-1:0]            dividend,
   input  logic [see_pkg::DVS_W-1:0] divisor,
   output logic                     done,
   output logic [DW-1:0]            quotient
);
   import see_pkg::*;

   localparam int CNT_W = $clog2(DW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    trial;
   logic              ge;

   assign trial    = {rem_ff, quo_ff[DW-1]};
   assign ge       = (trial >= {1'b0, dvs_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

// ----- design/see_front.sv -----
module see_front #(
   parameter int MAX_BINS   = see_pkg::MAX_BINS_DEF,
   parameter int MAX_POINTS = see_pkg::MAX_POINTS_DEF,
   localparam int AW = $clog2(MAX_BINS),
   localparam int CW = AW + 1,
   localparam int MW = $clog2(MAX_POINTS) + 1,
   localparam int JW = CW + MW + see_pkg::HALF_W + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [see_pkg::MAG_W-1:0]   magnitude,
   input  logic                        last_bin,
   output logic                        full,
   input  logic [see_pkg::SMOOTH_W-1:0] smoothing_width,
   input  logic [see_pkg::TARGET_W-1:0] target_points,
   output logic                        job_push,
   output logic [JW-1:0]               job_data,
   input  logic                        job_full,
   input  logic                        frame_done,
   input  logic [AW-1:0]               bin_addr,
   output logic [see_pkg::MAG_W-1:0]   bin_rdata
);
   import see_pkg::*;

   logic [MAG_W-1:0]    bin_mem [MAX_BINS];
   logic [MAG_W-1:0]    bin_rdata_ff;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic                wait_ff, wait_in;
   logic                accept, room;
   logic [CW-1:0]       n_frame;
   logic [TARGET_W-1:0] m_clamp;

   assign full      = wait_ff || job_full;
   assign accept    = push && !full;
   assign room      = (cnt_ff < CW'(MAX_BINS));
   assign bin_rdata = bin_rdata_ff;
   assign n_frame   = room ? cnt_ff + 1'b1 : CW'(MAX_BINS);

   always_comb begin
      if (target_points < TARGET_MIN) begin
         m_clamp = TARGET_MIN;
      end else if (target_points > TARGET_W'(MAX_POINTS)) begin
         m_clamp = TARGET_W'(MAX_POINTS);
      end else begin
         m_clamp = target_points;
      end
   end

   assign job_push = accept && last_bin;
   assign job_data = {n_frame, MW'(m_clamp), HALF_W'(smoothing_width >> 1),
                      ovf_ff || !room};

   always_comb begin
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      wait_in = wait_ff;
      if (frame_done) begin
         wait_in = 1'b0;
      end
      if (accept) begin
         if (room) begin
            cnt_in = cnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
         if (last_bin) begin
            cnt_in  = '0;
            ovf_in  = 1'b0;
            wait_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         wait_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
         wait_ff <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && room) begin
         bin_mem[cnt_ff[AW-1:0]] <= magnitude;
      end
      bin_rdata_ff <= bin_mem[bin_addr];
   end

endmodule

// ----- design/see_back.sv -----
module see_back #(
   parameter int MAX_BINS   = see_pkg::MAX_BINS_DEF,
   parameter int MAX_POINTS = see_pkg::MAX_POINTS_DEF,
   localparam int AW = $clog2(MAX_BINS),
   localparam int CW = AW + 1,
   localparam int MW = $clog2(MAX_POINTS) + 1,
   localparam int JW = CW + MW + see_pkg::HALF_W + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_empty,
   input  logic [JW-1:0]              job_data,
   output logic                       job_pop,
   output logic [AW-1:0]              bin_addr,
   input  logic [see_pkg::MAG_W-1:0]  bin_rdata,
   output logic                       res_push,
   output logic [see_pkg::RES_W-1:0]  res_data,
   input  logic                       res_full,
   output logic                       frame_done
);
   import see_pkg::*;

   localparam int PW = (MW > 1) ? MW - 1 : 1;
   localparam int EW = ((CW > HALF_W) ? CW : HALF_W) + 1;
   localparam int DW = (PW + AW + FRAC_W > SUM_W + 1) ? PW + AW + FRAC_W : SUM_W + 1;

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_PRE_RD   = 5'd1;
   localparam logic [4:0] ST_PRE_ACC  = 5'd2;
   localparam logic [4:0] ST_STEP     = 5'd3;
   localparam logic [4:0] ST_ADD_ACC  = 5'd4;
   localparam logic [4:0] ST_SUB_ACC  = 5'd5;
   localparam logic [4:0] ST_DIV      = 5'd6;
   localparam logic [4:0] ST_DIV_WAIT = 5'd7;
   localparam logic [4:0] ST_OUT_SEL  = 5'd8;
   localparam logic [4:0] ST_COPY_RD  = 5'd9;
   localparam logic [4:0] ST_COPY_PSH = 5'd10;
   localparam logic [4:0] ST_POS      = 5'd11;
   localparam logic [4:0] ST_POS_WAIT = 5'd12;
   localparam logic [4:0] ST_LO_RD    = 5'd13;
   localparam logic [4:0] ST_HI_RD    = 5'd14;
   localparam logic [4:0] ST_MUL      = 5'd15;
   localparam logic [4:0] ST_INT_PSH  = 5'd16;

   logic [4:0]        st_ff, st_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [MW-1:0]     m_ff, m_in;
   logic [HALF_W-1:0] half_ff, half_in;
   logic              ovf_ff, ovf_in;
   logic [CW-1:0]     i_ff, i_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [DW-1:0]     pos_ff, pos_in;
   logic [MAG_W-1:0]  slo_ff, slo_in;
   logic signed [41:0] prod_ff, prod_in;

   logic [MAG_W-1:0]  sm_mem [MAX_BINS];
   logic [MAG_W-1:0]  sm_rdata_ff;
   logic [AW-1:0]     sm_addr;
   logic              sm_we;

   logic              div_start, div_done;
   logic [DW-1:0]     div_dvd, div_q;
   logic [DVS_W-1:0]  div_dvs;

   logic [CW-1:0]     n_m1;
   logic [EW-1:0]     i_e, h_e, n_e, m_e, add_e, sub_e, hi_e, lo_e, win_e, pre_n;
   logic              add_ok, sub_ok, pre_last, last_n, last_m;
   logic [DVS_W-1:0]  win;
   logic [PW+AW-1:0]  ip;
   logic [AW-1:0]     lo_idx, hi_idx;
   logic [CW-1:0]     lo1;
   logic [FRAC_W-1:0] frac;
   logic signed [FRAC_W:0] frac_s;
   logic signed [MAG_W:0]  diff;
   logic signed [41:0] acc;
   logic [MAG_W-1:0]  interp;

   see_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   assign n_m1   = n_ff - 1'b1;
   assign i_e    = EW'(i_ff);
   assign h_e    = EW'(half_ff);
   assign n_e    = EW'(n_ff);
   assign m_e    = EW'(m_ff);
   assign add_e  = i_e + h_e;
   assign add_ok = (add_e < n_e);
   assign sub_ok = (i_e > h_e);
   assign sub_e  = i_e - h_e - 1'b1;
   assign hi_e   = add_ok ? add_e : n_e - 1'b1;
   assign lo_e   = sub_ok ? i_e - h_e : '0;
   assign win_e  = hi_e - lo_e + 1'b1;
   assign win    = DVS_W'(win_e);
   assign pre_n  = (h_e < n_e) ? h_e : n_e;
   assign pre_last = (i_e + 1'b1 == pre_n);
   assign last_n = (i_ff == n_m1);
   assign last_m = (i_e == m_e - 1'b1);

   assign ip     = (PW + AW)'(PW'(i_ff)) * (PW + AW)'(AW'(n_m1));
   assign lo_idx = pos_ff[AW+FRAC_W-1:FRAC_W];
   assign frac   = pos_ff[FRAC_W-1:0];
   assign lo1    = {1'b0, lo_idx} + 1'b1;
   assign hi_idx = (lo1 < n_ff) ? lo1[AW-1:0] : n_m1[AW-1:0];
   assign frac_s = {1'b0, frac};
   assign diff   = $signed({1'b0, sm_rdata_ff}) - $signed({1'b0, slo_ff});
   assign acc    = $signed({{(42-MAG_W-FRAC_W){1'b0}}, slo_ff, {FRAC_W{1'b0}}}) + prod_ff;
   assign interp = acc[MAG_W+FRAC_W-1:FRAC_W];

   always_comb begin
      st_in      = st_ff;
      n_in       = n_ff;
      m_in       = m_ff;
      half_in    = half_ff;
      ovf_in     = ovf_ff;
      i_in       = i_ff;
      sum_in     = sum_ff;
      pos_in     = pos_ff;
      slo_in     = slo_ff;
      prod_in    = prod_ff;
      job_pop    = 1'b0;
      bin_addr   = i_ff[AW-1:0];
      sm_addr    = i_ff[AW-1:0];
      sm_we      = 1'b0;
      div_start  = 1'b0;
      div_dvd    = DW'(sum_ff) + DW'(win >> 1);
      div_dvs    = win;
      res_push   = 1'b0;
      res_data   = {sm_rdata_ff, POINT_IDX_W'(i_ff), last_n, ovf_ff};
      frame_done = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               {n_in, m_in, half_in, ovf_in} = job_data;
               i_in    = '0;
               sum_in  = '0;
               st_in   = (job_data[HALF_W:1] == '0) ? ST_STEP : ST_PRE_RD;
            end
         end
         ST_PRE_RD: begin
            st_in = ST_PRE_ACC;
         end
         ST_PRE_ACC: begin
            sum_in = sum_ff + SUM_W'(bin_rdata);
            if (pre_last) begin
               i_in  = '0;
               st_in = ST_STEP;
            end else begin
               i_in  = i_ff + 1'b1;
               st_in = ST_PRE_RD;
            end
         end
         ST_STEP: begin
            if (add_ok) begin
               bin_addr = add_e[AW-1:0];
               st_in    = ST_ADD_ACC;
            end else if (sub_ok) begin
               bin_addr = sub_e[AW-1:0];
               st_in    = ST_SUB_ACC;
            end else begin
               st_in = ST_DIV;
            end
         end
         ST_ADD_ACC: begin
            sum_in = sum_ff + SUM_W'(bin_rdata);
            if (sub_ok) begin
               bin_addr = sub_e[AW-1:0];
               st_in    = ST_SUB_ACC;
            end else begin
               st_in = ST_DIV;
            end
         end
         ST_SUB_ACC: begin
            sum_in = sum_ff - SUM_W'(bin_rdata);
            st_in  = ST_DIV;
         end
         ST_DIV: begin
            div_start = 1'b1;
            st_in     = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               sm_we = 1'b1;
               if (last_n) begin
                  i_in  = '0;
                  st_in = ST_OUT_SEL;
               end else begin
                  i_in  = i_ff + 1'b1;
                  st_in = ST_STEP;
               end
            end
         end
         ST_OUT_SEL: begin
            st_in = (n_e <= m_e) ? ST_COPY_RD : ST_POS;
         end
         ST_COPY_RD: begin
            st_in = ST_COPY_PSH;
         end
         ST_COPY_PSH: begin
            if (!res_full) begin
               res_push = 1'b1;
               if (last_n) begin
                  frame_done = 1'b1;
                  st_in      = ST_IDLE;
               end else begin
                  i_in  = i_ff + 1'b1;
                  st_in = ST_COPY_RD;
               end
            end
         end
         ST_POS: begin
            div_start = 1'b1;
            div_dvd   = DW'({ip, {FRAC_W{1'b0}}});
            div_dvs   = DVS_W'(m_ff - 1'b1);
            st_in     = ST_POS_WAIT;
         end
         ST_POS_WAIT: begin
            if (div_done) begin
               pos_in = div_q;
               st_in  = ST_LO_RD;
            end
         end
         ST_LO_RD: begin
            sm_addr = lo_idx;
            st_in   = ST_HI_RD;
         end
         ST_HI_RD: begin
            slo_in  = sm_rdata_ff;
            sm_addr = hi_idx;
            st_in   = ST_MUL;
         end
         ST_MUL: begin
            prod_in = frac_s * diff;
            st_in   = ST_INT_PSH;
         end
         ST_INT_PSH: begin
            res_data = {interp, POINT_IDX_W'(i_ff), last_m, ovf_ff};
            if (!res_full) begin
               res_push = 1'b1;
               if (last_m) begin
                  frame_done = 1'b1;
                  st_in      = ST_IDLE;
               end else begin
                  i_in  = i_ff + 1'b1;
                  st_in = ST_POS;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      m_ff    <= m_in;
      half_ff <= half_in;
      ovf_ff  <= ovf_in;
      i_ff    <= i_in;
      sum_ff  <= sum_in;
      pos_ff  <= pos_in;
      slo_ff  <= slo_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (sm_we) begin
         sm_mem[i_ff[AW-1:0]] <= div_q[MAG_W-1:0];
      end
      sm_rdata_ff <= sm_mem[sm_addr];
   end

endmodule

// ----- test/spectral_envelope_extractor_test.sv -----
`timescale 1ns / 100ps

module spectral_envelope_extractor_test;
   import see_pkg::*;

   typedef struct {
      logic [MAG_W-1:0]       value;
      logic [POINT_IDX_W-1:0] index;
      logic                   last;
      logic                   trunc;
   } point_type;

   typedef enum int {ROW_BIN, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic             reg_sel;
      int unsigned      value;
      logic             last;
      bit               typed;
      point_type        point;
   } row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [MAG_W-1:0]       req_magnitude = '0;
   logic                   req_last_bin = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [MAG_W-1:0]       rsp_envelope_value;
   logic [POINT_IDX_W-1:0] rsp_point_index;
   logic                   rsp_last_point;
   logic                   rsp_truncated;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   point_type        envelope_q[$];
   row_type          rows[$];
   logic [MAG_W-1:0] frame_bins[MAX_BINS_DEF];
   logic [MAG_W-1:0] smoothed[MAX_BINS_DEF];
   int unsigned      bin_cnt = 0;
   bit               frame_ovf = 0;
   int unsigned      smooth_width = SMOOTH_RESET;
   int unsigned      target_pts = TARGET_RESET;
   int unsigned      send_gap = 23;
   int unsigned      take_gap = 63;
   int unsigned      mismatches = 0;

   spectral_envelope_extractor DUT (.*);

   always #2 clock = ~clock;

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

   // predictor: store a bin, on the last bin build the envelope
   task automatic take_bin(input logic [MAG_W-1:0] mag, input logic last, input bit keep);
      int unsigned n, m, half, lo, hi, cnt, f;
      longint unsigned sum, pos, acc;
      point_type p;
      if (bin_cnt < MAX_BINS_DEF) begin
         frame_bins[bin_cnt] = mag;
         bin_cnt++;
      end else begin
         frame_ovf = 1;
      end
      if (!last) return;
      n = bin_cnt;
      m = target_pts < 2 ? 2 : (target_pts > MAX_POINTS_DEF ? MAX_POINTS_DEF : target_pts);
      half = smooth_width / 2;
      for (int i = 0; i < n; i++) begin
         lo = i > half ? i - half : 0;
         hi = i + half;
         if (hi > n - 1) hi = n - 1;
         sum = 0;
         for (int j = lo; j <= hi; j++) sum += frame_bins[j];
         cnt = hi - lo + 1;
         smoothed[i] = MAG_W'((sum + cnt / 2) / cnt);
      end
      for (int i = 0; i < (n <= m ? n : m); i++) begin
         if (n <= m) begin
            p.value = smoothed[i];
            p.last = (i == n - 1);
         end else begin
            pos = (longint'(i) * (n - 1) * 65536) / (m - 1);
            lo = 32'(pos >> 16);
            f = 32'(pos & 16'hFFFF);
            if (lo > n - 1) lo = n - 1;
            hi = (lo + 1 < n) ? lo + 1 : n - 1;
            acc = longint'(smoothed[lo]) * (65536 - f) + longint'(smoothed[hi]) * f;
            p.value = MAG_W'(acc >> 16);
            p.last = (i == m - 1);
         end
         p.index = POINT_IDX_W'(i);
         p.trunc = frame_ovf;
         if (keep) envelope_q.insert(envelope_q.size(), p);
      end
      bin_cnt = 0;
      frame_ovf = 0;
   endtask

   task automatic push_bin(input logic [MAG_W-1:0] mag, input logic last, input bit keep);
      while ($urandom_range(99) < send_gap) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_magnitude <= mag;
      req_last_bin <= last;
      do @(posedge clock); while (req_full);
      take_bin(mag, last, keep);
   endtask

   task automatic drain;
      @(negedge clock);
      req_push <= 1'b0;
      wait (envelope_q.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic sel, input int unsigned value);
      drain();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (sel == REG_SMOOTH) smooth_width = value & 8'hFF;
      else target_pts = value & 7'h7F;
   endtask

   task automatic add_bin(input int unsigned mag, input logic last);
      row_type r;
      r = '{ROW_BIN, REG_SMOOTH, mag, last, 0, '{0, 0, 0, 0}};
      rows.insert(rows.size(), r);
   endtask

   task automatic add_typed(input int unsigned mag, input point_type p);
      row_type r;
      r = '{ROW_BIN, REG_SMOOTH, mag, 1'b1, 1, p};
      rows.insert(rows.size(), r);
   endtask

   task automatic add_cfg(input logic sel, input int unsigned value);
      row_type r;
      r = '{ROW_CFG, sel, value, 1'b0, 0, '{0, 0, 0, 0}};
      rows.insert(rows.size(), r);
   endtask

   always @(negedge clock)
      rsp_pop <= ($urandom_range(99) >= take_gap);

   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (envelope_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected point %h idx %0d", rsp_envelope_value, rsp_point_index);
         end else begin
            e = envelope_q.pop_front();
            if (rsp_envelope_value !== e.value || rsp_point_index !== e.index ||
                rsp_last_point !== e.last || rsp_truncated !== e.trunc) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("point mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                           e.value, e.index, e.last, e.trunc, rsp_envelope_value,
                           rsp_point_index, rsp_last_point, rsp_truncated);
            end
         end
      end
   end

   initial begin
      int unsigned sent, len;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      add_typed(0, '{24'h0, 6'd0, 1'b1, 1'b0});
      add_typed(24'hFFFFFF, '{24'hFFFFFF, 6'd0, 1'b1, 1'b0});
      add_cfg(REG_SMOOTH, 0);
      add_bin(24'hFFFFFF, 0); add_bin(0, 0); add_bin(24'hFFFFFF, 1);
      add_cfg(REG_SMOOTH, 255);
      add_bin(1, 0); add_bin(2, 0); add_bin(3, 0); add_bin(24'hFFFFFF, 1);
      add_cfg(REG_TARGET, 0);
      add_bin(10, 0); add_bin(20, 0); add_bin(30, 0); add_bin(40, 0); add_bin(50, 1);
      add_cfg(REG_TARGET, 127);
      add_cfg(REG_SMOOTH, 1);
      add_bin(7, 0); add_bin(24'h800000, 0); add_bin(9, 1);
      add_cfg(REG_TARGET, 2);
      add_bin(100, 0); add_bin(24'hABCDEF, 0); add_bin(300, 1);
      foreach (rows[k]) begin
         if (rows[k].kind == ROW_CFG) begin
            write_reg(rows[k].reg_sel, rows[k].value);
         end else begin
            push_bin(MAG_W'(rows[k].value), rows[k].last, !rows[k].typed);
            if (rows[k].typed) envelope_q.insert(envelope_q.size(), rows[k].point);
         end
      end

      // random frames over three idling phases
      write_reg(REG_SMOOTH, SMOOTH_RESET);
      write_reg(REG_TARGET, 64);
      sent = 0;
      while (sent < 300) begin
         if (sent >= 200) begin
            send_gap = 0;
            take_gap = 0;
         end else if (sent >= 100) begin
            send_gap = 63;
            take_gap = 23;
         end
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(3))
               0: write_reg(REG_SMOOTH, $urandom_range(255));
               1: write_reg(REG_TARGET, $urandom_range(127));
               2: write_reg(REG_SMOOTH, $urandom_range(1) ? 255 : $urandom_range(1));
               default: write_reg(REG_TARGET, $urandom_range(1) ? 64 : 2);
            endcase
         end
         len = ($urandom_range(4) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 20);
         for (int b = 0; b < len; b++)
            push_bin(MAG_W'($urandom), b == len - 1, 1);
         sent += len;
         if ($urandom_range(4) == 0) drain();
      end

      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && envelope_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/see_pkg.sv
design/see_fifo.sv
design/see_div.sv
design/see_front.sv
design/see_back.sv
design/spectral_envelope_extractor.sv
test/spectral_envelope_extractor_test.sv
